/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked on clk_i and disabled during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every enabled clock edge
`define LCG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("lcg64r assertion failed");

// expression must never be true
`define LCG_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("lcg64r forbidden condition seen");

`endif

/* sv/lcg64r_pkg.sv */
// ----------------------------------------------------------------------------
// lcg64r_pkg
// shared widths, constants, modes and control structs of the 64-bit lcg
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lcg64r_pkg;

  localparam int unsigned DataW  = 64;
  localparam int unsigned HalfW  = DataW / 2;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned FracW  = 53;
  localparam int unsigned CntW   = $clog2(DataW);
  localparam int unsigned MulSteps = 3;

  localparam logic [DataW-1:0] LcgMult   = 64'd6364136223846793005;
  localparam logic [DataW-1:0] LcgInc    = 64'd1442695040888963407;
  localparam logic [DataW-1:0] SeedReset = 64'h853c49e6748fea9b;

  typedef enum logic [ModeW-1:0] {
    MODE_FULL  = 2'd0,
    MODE_UPPER = 2'd1,
    MODE_RANGE = 2'd2,
    MODE_FRAC  = 2'd3
  } mode_e;

  // controller to datapath
  typedef struct packed {
    logic       load_req;
    logic       mul_step;
    logic [1:0] mul_idx;
    logic       inc;
    logic       div_step;
    logic       load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic deg;
    logic full_span;
    logic range_mode;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

/* sv/lcg64r_req_if.sv */
// ----------------------------------------------------------------------------
// lcg64r_req_if
// request channel: mode and inclusive range bounds
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lcg64r_req_if;
  logic                          valid;
  logic                          ready;
  logic [lcg64r_pkg::ModeW-1:0]  mode;
  logic [lcg64r_pkg::DataW-1:0]  range_low;
  logic [lcg64r_pkg::DataW-1:0]  range_high;

  modport source (output valid, output mode, output range_low, output range_high,
                  input ready);
  modport sink   (input valid, input mode, input range_low, input range_high,
                  output ready);
endinterface

`default_nettype wire

/* sv/lcg64r_rsp_if.sv */
// ----------------------------------------------------------------------------
// lcg64r_rsp_if
// result channel: one random value per request
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lcg64r_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [lcg64r_pkg::DataW-1:0]  random_value;

  modport source (output valid, output random_value, input ready);
  modport sink   (input valid, input random_value, output ready);
endinterface

`default_nettype wire

/* sv/lcg64r_ctrl.sv */
// ----------------------------------------------------------------------------
// lcg64r_ctrl
// sequencer: multiply steps, increment, bit-serial remainder, result load
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module lcg64r_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire lcg64r_pkg::status_t  status_i,
  output lcg64r_pkg::cmd_t          cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_INC,
    S_DIV,
    S_DONE
  } state_e;

  localparam logic [lcg64r_pkg::CntW-1:0] MulLast =
    lcg64r_pkg::CntW'(lcg64r_pkg::MulSteps - 1);
  localparam logic [lcg64r_pkg::CntW-1:0] DivLast =
    lcg64r_pkg::CntW'(lcg64r_pkg::DataW - 1);

  state_e                        state_q, state_d;
  logic [lcg64r_pkg::CntW-1:0]   cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.mul_idx = cnt_q[1:0];
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          cnt_d   = '0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        // single-value or inverted range leaves the state untouched
        if (status_i.deg) begin
          state_d = S_DONE;
        end else begin
          cmd_o.mul_step = 1'b1;
          if (cnt_q == MulLast) begin
            cnt_d   = '0;
            state_d = S_INC;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      S_INC: begin
        cmd_o.inc = 1'b1;
        cnt_d     = '0;
        if (status_i.range_mode && !status_i.full_span) begin
          state_d = S_DIV;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == DivLast) begin
          state_d = S_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  `LCG_ASSERT(a_accept_starts_mul, (in_valid_i && in_ready_o) |=> (state_q == S_MUL && cnt_q == '0))
  `LCG_ASSERT(a_div_ends, (state_q == S_DIV && cnt_q == DivLast) |=> (state_q == S_DONE))
  `LCG_ASSERT_NEVER(a_div_skipped_range, cmd_o.inc && status_i.deg)

endmodule

`default_nettype wire

/* sv/lcg64r_dp.sv */
// ----------------------------------------------------------------------------
// lcg64r_dp
// generator state, shared 32x32 multiplier, restoring remainder unit and
// output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module lcg64r_dp (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           seed_we_i,
  input  wire logic [lcg64r_pkg::DataW-1:0]   seed_wdata_i,
  input  wire logic [lcg64r_pkg::ModeW-1:0]   mode_i,
  input  wire logic [lcg64r_pkg::DataW-1:0]   range_low_i,
  input  wire logic [lcg64r_pkg::DataW-1:0]   range_high_i,
  input  wire lcg64r_pkg::cmd_t               cmd_i,
  output lcg64r_pkg::status_t                 status_o,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [lcg64r_pkg::DataW-1:0]        out_data_o
);

  localparam int unsigned W = lcg64r_pkg::DataW;
  localparam int unsigned H = lcg64r_pkg::HalfW;

  logic [W-1:0]  state_q, state_d;
  logic [W-1:0]  acc_q, acc_d;
  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  dvd_q, dvd_d;
  logic [W-1:0]  low_q, span_q;
  lcg64r_pkg::mode_e mode_q;
  logic          deg_q;
  logic [W-1:0]  out_q, out_d;
  logic          out_valid_q;

  logic [H-1:0]  mul_a, mul_b;
  logic [W-1:0]  mul_p;
  logic [W-1:0]  next_state;
  logic [W:0]    rem_shift, rem_trial;
  logic [W-1:0]  seed_fix;

  // low 64 bits of state * mult: lo*lo, then both cross terms shifted up
  always_comb begin
    case (cmd_i.mul_idx)
      2'd0:    begin mul_a = state_q[H-1:0]; mul_b = lcg64r_pkg::LcgMult[H-1:0]; end
      2'd1:    begin mul_a = state_q[H-1:0]; mul_b = lcg64r_pkg::LcgMult[W-1:H]; end
      default: begin mul_a = state_q[W-1:H]; mul_b = lcg64r_pkg::LcgMult[H-1:0]; end
    endcase
  end

  assign mul_p      = {{H{1'b0}}, mul_a} * {{H{1'b0}}, mul_b};
  assign next_state = acc_q + lcg64r_pkg::LcgInc;
  assign seed_fix   = (seed_wdata_i == '0) ? W'(1) : seed_wdata_i;

  assign rem_shift = {rem_q, dvd_q[W-1]};
  assign rem_trial = rem_shift - {1'b0, span_q};

  always_comb begin
    acc_d   = acc_q;
    state_d = state_q;
    rem_d   = rem_q;
    dvd_d   = dvd_q;
    if (cmd_i.mul_step) begin
      if (cmd_i.mul_idx == 2'd0) begin
        acc_d = mul_p;
      end else begin
        acc_d = acc_q + {mul_p[H-1:0], {H{1'b0}}};
      end
    end
    if (cmd_i.inc) begin
      state_d = next_state;
      dvd_d   = next_state;
      rem_d   = '0;
    end else if (seed_we_i) begin
      state_d = seed_fix;
    end
    if (cmd_i.div_step) begin
      // restoring step, one dividend bit per cycle
      rem_d = rem_trial[W] ? rem_shift[W-1:0] : rem_trial[W-1:0];
      dvd_d = {dvd_q[W-2:0], 1'b0};
    end
  end

  always_comb begin
    case (mode_q)
      lcg64r_pkg::MODE_FULL:  out_d = state_q;
      lcg64r_pkg::MODE_UPPER: out_d = {{H{1'b0}}, state_q[W-1:H]};
      lcg64r_pkg::MODE_RANGE: begin
        if (deg_q) begin
          out_d = low_q;
        end else if (span_q == '0) begin
          out_d = state_q;
        end else begin
          out_d = low_q + rem_q;
        end
      end
      default: out_d = {{(W - lcg64r_pkg::FracW){1'b0}},
                        state_q[W-1:W-lcg64r_pkg::FracW]};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lcg64r_pkg::SeedReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    if (cmd_i.load_req) begin
      mode_q <= lcg64r_pkg::mode_e'(mode_i);
      low_q  <= range_low_i;
      span_q <= range_high_i - range_low_i + W'(1);
      deg_q  <= (lcg64r_pkg::mode_e'(mode_i) == lcg64r_pkg::MODE_RANGE)
                && (range_low_i >= range_high_i);
    end
    if (cmd_i.load_out) begin
      out_q <= out_d;
    end
  end

  assign status_o.deg        = deg_q;
  assign status_o.full_span  = (span_q == '0);
  assign status_o.range_mode = (mode_q == lcg64r_pkg::MODE_RANGE);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `LCG_ASSERT(a_load_sets_valid, cmd_i.load_out |=> out_valid_q)
  `LCG_ASSERT(a_rem_below_span, cmd_i.div_step |-> (rem_q < span_q))
  `LCG_ASSERT_NEVER(a_load_over_full, cmd_i.load_out && out_valid_q && !out_ready_i)

endmodule

`default_nettype wire

/* sv/lcg64_random_with_range.sv */
// ----------------------------------------------------------------------------
// lcg64_random_with_range
// 64-bit linear congruential generator with bounded range and fraction modes
// ----------------------------------------------------------------------------
// Each request advances the 64-bit state once (state * 6364136223846793005 +
// 1442695040888963407) and returns the new state, its upper half, a value in
// [range_low, range_high] or the top 53 bits as a U0.53 fraction. One request
// is in work at a time. The state update runs its multiply steps on one shared
// 32x32 multiplier, then an increment step; a bounded range then adds the
// bit-serial remainder unit. A single-value or inverted range returns
// range_low without the multiply steps and leaves the state alone. The result
// sits in an output register, so the next request is accepted while it waits.
// The user must write the seed (zero loads one) only while no request is in
// work; the block itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module lcg64_random_with_range (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          seed_we_i,
  input  wire logic [lcg64r_pkg::DataW-1:0]  seed_wdata_i,
  lcg64r_req_if.sink                         req_i,
  lcg64r_rsp_if.source                       rsp_o
);

  lcg64r_pkg::cmd_t     cmd;
  lcg64r_pkg::status_t  status;
  logic                 in_ready;
  logic                 out_valid;
  logic [lcg64r_pkg::DataW-1:0] out_data;

  lcg64r_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lcg64r_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .seed_we_i    (seed_we_i),
    .seed_wdata_i (seed_wdata_i),
    .mode_i       (req_i.mode),
    .range_low_i  (req_i.range_low),
    .range_high_i (req_i.range_high),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (out_valid),
    .out_ready_i  (rsp_o.ready),
    .out_data_o   (out_data)
  );

  assign req_i.ready        = in_ready;
  assign rsp_o.valid        = out_valid;
  assign rsp_o.random_value = out_data;

endmodule

`default_nettype wire
